FILE: rtl/dssp_pkg.sv
package dssp_pkg;

    localparam int DEF_MAX_LENGTH = 4096;
    localparam int DEF_MAX_NEST   = 255;
    localparam int DEF_SPEC_MAX   = 10;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BANG   = 8'h21;

    localparam logic [1:0] KIND_LIT   = 2'd0;
    localparam logic [1:0] KIND_OPEN  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_EXPR  = 2'd3;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LIT  = 2'd1;
    localparam logic [1:0] MODE_EXPR = 2'd2;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_OPEN  = 2'd1;
    localparam logic [1:0] PEND_CLOSE = 2'd2;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic is_spec_char(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                         CH_LBRACK, CH_RBRACK, CH_BANG};
    endfunction

endpackage

FILE: rtl/display_string_part_splitter.sv
// Channel | Direction | Handshake          | Payload
// request | in        | i_valid / o_stall  | i_text_byte, i_final_byte
// part    | out       | o_valid / i_stall  | o_part_kind .. o_run_last
//
// One template byte is taken per cycle while o_stall is low; a byte yields
// zero to three parts. A byte is registered, parsed combinationally and its
// parts pushed into an eight-entry part queue; the output drains one part per
// cycle while i_stall is low.
// o_stall rises while a byte waits and the queue has fewer than three free entries.
// Reset is synchronous; no clearing pass follows.
module display_string_part_splitter #(
    parameter int MAX_LENGTH = dssp_pkg::DEF_MAX_LENGTH,
    parameter int MAX_NEST   = dssp_pkg::DEF_MAX_NEST,
    parameter int SPEC_MAX   = dssp_pkg::DEF_SPEC_MAX,
    localparam int POS_W     = $clog2(MAX_LENGTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_text_byte,
    input  logic             i_final_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_part_kind,
    output logic [POS_W-1:0] o_text_begin,
    output logic [POS_W-1:0] o_text_end,
    output logic             o_has_spec,
    output logic [POS_W-1:0] o_spec_begin,
    output logic [POS_W-1:0] o_spec_end,
    output logic             o_string_done,
    output logic             o_run_last
);
    import dssp_pkg::*;

    localparam int NEST_W = $clog2(MAX_NEST + 1);
    localparam int SC_W   = $clog2(SPEC_MAX + 2);
    localparam int DEPTH  = 8;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [POS_W:0]    LEN_LIM  = (POS_W + 1)'(MAX_LENGTH);
    localparam logic [NEST_W-1:0] NEST_LIM = NEST_W'(MAX_NEST);
    localparam logic [SC_W-1:0]   SPEC_LIM = SC_W'(SPEC_MAX);
    localparam logic [CNT_W-1:0]  ROOM_LIM = CNT_W'(DEPTH - 3);

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] tb;
        logic [POS_W-1:0] te;
        logic             hs;
        logic [POS_W-1:0] sb;
        logic [POS_W-1:0] se;
        logic             done;
        logic             last;
    } t_part;

    function automatic logic [POS_W-1:0] clamp_inc(input logic [POS_W-1:0] x);
        logic [POS_W:0] s;
        s = {1'b0, x} + 1'b1;
        return (s > LEN_LIM) ? LEN_LIM[POS_W-1:0] : s[POS_W-1:0];
    endfunction

    function automatic t_part mk_part(input logic [1:0] kind,
                                      input logic [POS_W-1:0] tb,
                                      input logic [POS_W-1:0] te,
                                      input logic hs,
                                      input logic [POS_W-1:0] sb,
                                      input logic [POS_W-1:0] se);
        t_part r;
        r = '0;
        r.kind = kind;
        r.tb = tb;
        r.te = te;
        r.hs = hs;
        r.sb = sb;
        r.se = se;
        return r;
    endfunction

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    // parse state
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [1:0]        r_mode, n_mode;
    logic [1:0]        r_pend, n_pend;
    logic [POS_W-1:0]  r_pend_pos, n_pend_pos;
    logic [NEST_W-1:0] r_brace, n_brace;
    logic [NEST_W-1:0] r_bracket, n_bracket;
    logic [POS_W-1:0]  r_part_start, n_part_start;
    logic [POS_W-1:0]  r_first_nb, n_first_nb;
    logic [POS_W-1:0]  r_last_nb, n_last_nb;
    logic              r_nb_seen, n_nb_seen;
    logic              r_comma_seen, n_comma_seen;
    logic [POS_W-1:0]  r_te_comma, n_te_comma;
    logic [POS_W-1:0]  r_spec_first, n_spec_first;
    logic [POS_W-1:0]  r_spec_last, n_spec_last;
    logic              r_spec_ok, n_spec_ok;
    logic              r_spec_seen, n_spec_seen;
    logic              r_spec_gap, n_spec_gap;
    logic [SC_W-1:0]   r_spec_cnt, n_spec_cnt;

    // part queue
    t_part            r_fifo [DEPTH];
    logic [PTR_W-1:0] r_rd, r_wr;
    logic [CNT_W-1:0] r_count;

    logic             fire, accept, pop;
    logic [1:0]       n_cnt;
    t_part            res [3];
    logic             run_expr, run_top, closed, do_emit, spec_valid, blank, fresh;
    logic [POS_W-1:0] emit_end, p, cp1;
    logic [7:0]       c;
    logic             f;

    assign fire    = r_in_valid && (r_count <= ROOM_LIM);
    assign o_stall = r_in_valid && (r_count > ROOM_LIM);
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;

    assign c   = r_in_byte;
    assign f   = r_in_final;
    assign p   = r_pos;
    assign cp1 = clamp_inc(r_pos);

    always_comb begin
        n_pos = r_pos;  n_mode = r_mode;  n_pend = r_pend;  n_pend_pos = r_pend_pos;
        n_brace = r_brace;  n_bracket = r_bracket;  n_part_start = r_part_start;
        n_first_nb = r_first_nb;  n_last_nb = r_last_nb;  n_nb_seen = r_nb_seen;
        n_comma_seen = r_comma_seen;  n_te_comma = r_te_comma;
        n_spec_first = r_spec_first;  n_spec_last = r_spec_last;  n_spec_ok = r_spec_ok;
        n_spec_seen = r_spec_seen;  n_spec_gap = r_spec_gap;  n_spec_cnt = r_spec_cnt;
        n_cnt = 2'd0;
        res[0] = '0;  res[1] = '0;  res[2] = '0;
        run_expr = 1'b0;  run_top = 1'b0;  closed = 1'b0;  do_emit = 1'b0;
        spec_valid = 1'b0;  fresh = 1'b0;  emit_end = '0;
        blank = is_blank(c);

        if (fire) begin
            if (r_pend == PEND_OPEN) begin
                n_pend = PEND_NONE;
                if (c == CH_LBRACE) begin
                    res[n_cnt] = mk_part(KIND_OPEN, r_pend_pos, clamp_inc(r_pend_pos),
                                         1'b0, '0, '0);
                    n_cnt = n_cnt + 2'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    n_mode = MODE_EXPR;  n_part_start = p;
                    n_brace = NEST_W'(1);  n_bracket = '0;
                    n_nb_seen = 1'b0;  n_first_nb = '0;  n_last_nb = '0;
                    n_comma_seen = 1'b0;  n_te_comma = '0;
                    n_spec_ok = 1'b0;  n_spec_seen = 1'b0;  n_spec_gap = 1'b0;
                    n_spec_cnt = '0;  n_spec_first = '0;  n_spec_last = '0;
                    run_expr = 1'b1;
                end
            end else if (r_pend == PEND_CLOSE) begin
                n_pend = PEND_NONE;
                if (c == CH_RBRACE) begin
                    if (r_mode == MODE_LIT) begin
                        res[n_cnt] = mk_part(KIND_LIT, r_part_start, r_pend_pos,
                                             1'b0, '0, '0);
                        n_cnt = n_cnt + 2'd1;
                    end
                    res[n_cnt] = mk_part(KIND_CLOSE, r_pend_pos, clamp_inc(r_pend_pos),
                                         1'b0, '0, '0);
                    n_cnt = n_cnt + 2'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    res[n_cnt] = mk_part(KIND_LIT, r_part_start, clamp_inc(r_pend_pos),
                                         1'b0, '0, '0);
                    n_cnt = n_cnt + 2'd1;
                    n_mode = MODE_IDLE;
                    run_top = 1'b1;
                end
            end else if (r_mode == MODE_EXPR) begin
                run_expr = 1'b1;
            end else begin
                run_top = 1'b1;
            end

            if (run_expr) begin
                if (c == CH_RBRACE) begin
                    if (n_brace != '0) begin
                        n_brace = n_brace - 1'b1;
                    end
                    closed = (n_brace == '0);
                end else if (c == CH_LBRACE) begin
                    if (n_brace < NEST_LIM) begin
                        n_brace = n_brace + 1'b1;
                    end
                end
                if (closed) begin
                    do_emit = 1'b1;
                    emit_end = p;
                end else begin
                    if (c == CH_LPAREN || c == CH_LBRACK) begin
                        if (n_bracket < NEST_LIM) begin
                            n_bracket = n_bracket + 1'b1;
                        end
                    end else if (c == CH_RPAREN || c == CH_RBRACK) begin
                        if (n_bracket != '0) begin
                            n_bracket = n_bracket - 1'b1;
                        end
                    end else if (c == CH_COMMA && n_bracket == '0) begin
                        n_te_comma = n_nb_seen ? clamp_inc(n_last_nb) : p;
                        n_comma_seen = 1'b1;
                        n_spec_ok = 1'b1;  n_spec_seen = 1'b0;  n_spec_gap = 1'b0;
                        n_spec_cnt = '0;  n_spec_first = '0;  n_spec_last = '0;
                        fresh = 1'b1;
                    end
                    if (!blank) begin
                        if (!n_nb_seen) begin
                            n_first_nb = p;
                            n_nb_seen = 1'b1;
                        end
                        n_last_nb = p;
                    end
                    if (n_comma_seen && !fresh) begin
                        if (blank) begin
                            if (n_spec_seen) begin
                                n_spec_gap = 1'b1;
                            end
                        end else begin
                            if (n_spec_gap || !is_spec_char(c)) begin
                                n_spec_ok = 1'b0;
                            end
                            if (!n_spec_seen) begin
                                n_spec_first = p;
                                n_spec_seen = 1'b1;
                            end
                            n_spec_last = p;
                            if (n_spec_cnt <= SPEC_LIM) begin
                                n_spec_cnt = n_spec_cnt + 1'b1;
                            end
                        end
                    end
                    if (f) begin
                        do_emit = 1'b1;
                        emit_end = cp1;
                    end
                end
                if (do_emit) begin
                    spec_valid = n_comma_seen && n_spec_seen && n_spec_ok &&
                                 (n_spec_cnt <= SPEC_LIM);
                    if (spec_valid) begin
                        res[n_cnt] = mk_part(KIND_EXPR, n_first_nb, n_te_comma, 1'b1,
                                             n_spec_first, clamp_inc(n_spec_last));
                    end else begin
                        res[n_cnt] = mk_part(KIND_EXPR, n_part_start, emit_end,
                                             1'b0, '0, '0);
                    end
                    n_cnt = n_cnt + 2'd1;
                    n_mode = MODE_IDLE;
                end
            end

            if (run_top) begin
                if (c == CH_LBRACE) begin
                    if (n_mode == MODE_LIT) begin
                        res[n_cnt] = mk_part(KIND_LIT, n_part_start, p, 1'b0, '0, '0);
                        n_cnt = n_cnt + 2'd1;
                    end
                    n_mode = MODE_IDLE;
                    if (f) begin
                        res[n_cnt] = mk_part(KIND_EXPR, cp1, cp1, 1'b0, '0, '0);
                        n_cnt = n_cnt + 2'd1;
                    end else begin
                        n_pend = PEND_OPEN;
                        n_pend_pos = p;
                    end
                end else if (c == CH_RBRACE) begin
                    if (n_mode == MODE_IDLE) begin
                        n_part_start = p;
                    end
                    if (f) begin
                        res[n_cnt] = mk_part(KIND_LIT, n_part_start, cp1, 1'b0, '0, '0);
                        n_cnt = n_cnt + 2'd1;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_pend = PEND_CLOSE;
                        n_pend_pos = p;
                    end
                end else begin
                    if (n_mode == MODE_IDLE) begin
                        n_part_start = p;
                        n_mode = MODE_LIT;
                    end
                    if (f) begin
                        res[n_cnt] = mk_part(KIND_LIT, n_part_start, cp1, 1'b0, '0, '0);
                        n_cnt = n_cnt + 2'd1;
                        n_mode = MODE_IDLE;
                    end
                end
            end

            for (int i = 0; i < 3; i++) begin
                if (2'(i) + 2'd1 == n_cnt) begin
                    res[i].last = 1'b1;
                    res[i].done = f;
                end
            end

            if (f) begin
                n_pos = '0;  n_mode = MODE_IDLE;  n_pend = PEND_NONE;  n_pend_pos = '0;
                n_brace = '0;  n_bracket = '0;  n_part_start = '0;
                n_first_nb = '0;  n_last_nb = '0;  n_nb_seen = 1'b0;
                n_comma_seen = 1'b0;  n_te_comma = '0;
                n_spec_first = '0;  n_spec_last = '0;  n_spec_ok = 1'b0;
                n_spec_seen = 1'b0;  n_spec_gap = 1'b0;  n_spec_cnt = '0;
            end else begin
                n_pos = cp1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= i_text_byte;
            r_in_final <= i_final_byte;
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < n_cnt) begin
                r_fifo[r_wr + PTR_W'(i)] <= res[i];
            end
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_rd <= '0;
            r_wr <= '0;
            r_count <= '0;
            r_pos <= '0;  r_mode <= MODE_IDLE;  r_pend <= PEND_NONE;  r_pend_pos <= '0;
            r_brace <= '0;  r_bracket <= '0;  r_part_start <= '0;
            r_first_nb <= '0;  r_last_nb <= '0;  r_nb_seen <= 1'b0;
            r_comma_seen <= 1'b0;  r_te_comma <= '0;
            r_spec_first <= '0;  r_spec_last <= '0;  r_spec_ok <= 1'b0;
            r_spec_seen <= 1'b0;  r_spec_gap <= 1'b0;  r_spec_cnt <= '0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !fire);
            r_wr <= r_wr + PTR_W'(n_cnt);
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(n_cnt) - CNT_W'(pop);
            r_pos <= n_pos;  r_mode <= n_mode;  r_pend <= n_pend;  r_pend_pos <= n_pend_pos;
            r_brace <= n_brace;  r_bracket <= n_bracket;  r_part_start <= n_part_start;
            r_first_nb <= n_first_nb;  r_last_nb <= n_last_nb;  r_nb_seen <= n_nb_seen;
            r_comma_seen <= n_comma_seen;  r_te_comma <= n_te_comma;
            r_spec_first <= n_spec_first;  r_spec_last <= n_spec_last;
            r_spec_ok <= n_spec_ok;  r_spec_seen <= n_spec_seen;
            r_spec_gap <= n_spec_gap;  r_spec_cnt <= n_spec_cnt;
        end
    end

    assign o_part_kind   = r_fifo[r_rd].kind;
    assign o_text_begin  = r_fifo[r_rd].tb;
    assign o_text_end    = r_fifo[r_rd].te;
    assign o_has_spec    = r_fifo[r_rd].hs;
    assign o_spec_begin  = r_fifo[r_rd].sb;
    assign o_spec_end    = r_fifo[r_rd].se;
    assign o_string_done = r_fifo[r_rd].done;
    assign o_run_last    = r_fifo[r_rd].last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("part queue overflow");

    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_final |-> n_cnt != 2'd0)
        else $error("final byte produced no part");

    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_final |=> r_pos == '0 && r_mode == MODE_IDLE && r_pend == PEND_NONE)
        else $error("parser not idle after final byte");

    a_pend_not_expr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != PEND_NONE |-> r_mode != MODE_EXPR)
        else $error("pending brace inside expression");

    a_spec_only_expr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_part_kind != KIND_EXPR |-> !o_has_spec)
        else $error("specifier on non-expression part");

endmodule
